// ===== rtl/core/scba_pkg.sv =====
// Shared types, codes and fixed field widths of the size-class block allocator.
package scba_pkg;

	localparam int ADDR_W  = 16;
	localparam int SIZE_W  = 16;
	localparam int BLK_W   = 17;
	localparam int LIVE_W  = 8;
	localparam int COUNT_W = 12;
	localparam int BYTES_W = 16;
	localparam int OUT_CLASS_W = 3;
	localparam int STATUS_W = 2;

	// Widest chunk index and class code carried between modules.
	localparam int CHUNK_IDX_W = 10;
	localparam int CLASS_W     = 4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_CHUNK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ALLOC_SEL,
		ST_ALLOC_DONE,
		ST_FREE_DONE
	} scba_state_t;

	typedef enum logic [2:0] {
		PATH_POP,
		PATH_BUMP,
		PATH_CLAIM,
		PATH_TOO_BIG,
		PATH_NO_CHUNK
	} scba_path_t;

	typedef struct packed {
		logic                    op;
		logic [SIZE_W-1:0]       size;
		logic [ADDR_W-1:0]       address;
	} scba_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       block_address;
		logic [STATUS_W-1:0]     status;
		logic [OUT_CLASS_W-1:0]  size_class;
		logic [COUNT_W-1:0]      live_blocks;
		logic [BYTES_W-1:0]      live_bytes;
	} scba_rsp_t;

	typedef struct packed {
		logic                    rd_en;
		logic [CHUNK_IDX_W-1:0]  rd_idx;
		logic                    wr_live_en;
		logic                    wr_class_en;
		logic [CHUNK_IDX_W-1:0]  wr_idx;
		logic [CLASS_W-1:0]      wr_class;
		logic [LIVE_W-1:0]       wr_live;
	} scba_tbl_req_t;

endpackage

// ===== rtl/core/scba_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per handshake.
interface scba_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/size_class_block_allocator.sv =====
// Top level of the size-class block allocator: sequencer, free lists, bump state, counters.
//
// Size-class allocator over a pool of NUM_CHUNKS chunks of 2^CHUNK_BITS bytes in a
// 16-bit address space. Each item on req is an allocate (op 0, size in bytes) or a free
// (op 1, address); each item yields exactly one item on rsp carrying the granted address,
// a status, the class used and the live block and byte counts after the item. Requests
// are raised to 2^MIN_BLOCK_BITS and rounded up to a power of two; sizes above
// 2^MAX_BLOCK_BITS return status 1, and an allocate that needs a fresh chunk when the
// pool is spent returns status 2. The block works on one item at a time: an allocate
// takes four cycles from the accepting edge to the next possible accept and a free
// takes three, set by the class decode cycle and the registered reads of the link
// memory and the per-chunk table that each item must wait for. A result waiting on
// rsp stalls the block only when the next result is ready to be written; otherwise a
// new item is taken while the previous result is still held. No clearing pass runs
// after reset: the link memory and chunk table are only read at entries already
// written.
module size_class_block_allocator #(
	parameter int MIN_BLOCK_BITS = 4,
	parameter int MAX_BLOCK_BITS = 10,
	parameter int CHUNK_BITS     = 12,
	parameter int NUM_CHUNKS     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	scba_stream_if.sink          req,
	scba_stream_if.source        rsp
);
	import scba_pkg::*;

	localparam int NUM_CLASSES = MAX_BLOCK_BITS - MIN_BLOCK_BITS + 1;
	localparam int CLW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CIW  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int CTW  = $clog2(NUM_CHUNKS + 1);
	localparam int LIW  = ADDR_W - MIN_BLOCK_BITS;
	localparam int LINK_DEPTH = 1 << LIW;
	localparam int AW   = ((CHUNK_BITS > BLK_W) ? CHUNK_BITS : BLK_W) + 1;

	localparam logic [BLK_W-1:0] MIN_BLK = BLK_W'(1) << MIN_BLOCK_BITS;
	localparam logic [BLK_W-1:0] MAX_BLK = BLK_W'(1) << MAX_BLOCK_BITS;
	localparam logic [AW-1:0]    CHUNK_BYTES = AW'(1) << CHUNK_BITS;

	// ---------------------------------------------------------------- state
	scba_state_t              state_q, state_d;
	scba_path_t               path_q, path_c;

	logic                     op_q;
	logic [SIZE_W-1:0]        size_q;
	logic [ADDR_W-1:0]        addr_q;
	logic [CLW-1:0]           cls_q;
	logic [BLK_W-1:0]         blk_q;
	logic                     too_big_q;
	logic                     range_ok_q;
	logic [ADDR_W-1:0]        grant_q;
	logic [CIW-1:0]           chunk_q;
	logic                     chunk_ok_q;

	logic [ADDR_W-1:0]        free_head_q   [NUM_CLASSES];
	logic [CIW-1:0]           bump_chunk_q  [NUM_CLASSES];
	logic                     bump_valid_q  [NUM_CLASSES];
	logic [CHUNK_BITS-1:0]    bump_offset_q [NUM_CLASSES];
	logic [CTW-1:0]           chunks_taken_q;
	logic [COUNT_W-1:0]       live_count_q;
	logic [BYTES_W-1:0]       byte_count_q;

	logic [ADDR_W-1:0]        link_mem [LINK_DEPTH];
	logic [ADDR_W-1:0]        link_rd_q;

	scba_rsp_t                rsp_q;
	logic                     rsp_valid_q;

	// ---------------------------------------------------------------- control
	logic                     out_free;
	logic                     accept;
	logic                     tbl_rd_en;
	logic                     link_rd_en;
	logic                     alloc_commit;
	logic                     free_commit;

	scba_tbl_req_t            tbl_req;
	logic [CLW-1:0]           tbl_cls_rd;
	logic [LIVE_W-1:0]        tbl_live_rd;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (req.valid) state_d = ST_DECODE;
			ST_DECODE:     state_d = (op_q == OP_FREE) ? ST_FREE_DONE : ST_ALLOC_SEL;
			ST_ALLOC_SEL:  state_d = ST_ALLOC_DONE;
			ST_ALLOC_DONE: if (out_free) state_d = ST_IDLE;
			ST_FREE_DONE:  if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready    = 1'b0;
		tbl_rd_en    = 1'b0;
		link_rd_en   = 1'b0;
		alloc_commit = 1'b0;
		free_commit  = 1'b0;
		unique case (state_q)
			ST_IDLE:       req.ready = 1'b1;
			ST_DECODE:     tbl_rd_en = (op_q == OP_FREE);
			ST_ALLOC_SEL: begin
				tbl_rd_en  = 1'b1;
				link_rd_en = 1'b1;
			end
			ST_ALLOC_DONE: alloc_commit = out_free;
			ST_FREE_DONE:  free_commit  = out_free;
			default:       req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------- decode
	// Raise the size to the minimum block and find the ceiling power of two.
	logic [BLK_W-1:0] size_raised_c;
	logic [BLK_W-1:0] size_m1_c;
	logic [4:0]       hbit_c;
	logic [4:0]       cls5_c;
	logic             too_big_c;
	logic [ADDR_W-1:0] addr_chunk_c;
	logic             range_ok_c;

	always_comb begin
		size_raised_c = (BLK_W'(size_q) < MIN_BLK) ? MIN_BLK : BLK_W'(size_q);
		too_big_c     = size_raised_c > MAX_BLK;
		size_m1_c     = size_raised_c - BLK_W'(1);
		hbit_c        = '0;
		for (int i = 0; i < BLK_W; i++) begin
			if (size_m1_c[i]) hbit_c = 5'(i);
		end
		cls5_c = hbit_c + 5'd1 - 5'(MIN_BLOCK_BITS);
	end

	// Chunk of a freed address and its first range checks.
	always_comb begin
		addr_chunk_c = addr_q >> CHUNK_BITS;
		range_ok_c   = (addr_q != '0)
		            && (BLK_W'(addr_chunk_c) < BLK_W'(chunks_taken_q))
		            && (BLK_W'(addr_chunk_c) < BLK_W'(NUM_CHUNKS));
	end

	// ---------------------------------------------------------------- allocate select
	logic [ADDR_W-1:0] head_c;
	logic [ADDR_W-1:0] head_chunk_c;
	logic              head_ok_c;
	logic [31:0]       bump_base_c;
	logic [31:0]       bump_addr_c;
	logic [31:0]       claim_base_c;
	logic [ADDR_W-1:0] grant_c;
	logic [CIW-1:0]    chunk_sel_c;
	logic              chunk_ok_c;

	always_comb begin
		head_c       = free_head_q[cls_q];
		head_chunk_c = head_c >> CHUNK_BITS;
		head_ok_c    = BLK_W'(head_chunk_c) < BLK_W'(NUM_CHUNKS);
		bump_base_c  = 32'(bump_chunk_q[cls_q]) << CHUNK_BITS;
		bump_addr_c  = bump_base_c + 32'(bump_offset_q[cls_q]);
		claim_base_c = 32'(chunks_taken_q) << CHUNK_BITS;

		if (too_big_q) begin
			path_c = PATH_TOO_BIG;
		end else if (head_c != '0) begin
			path_c = PATH_POP;
		end else if (bump_valid_q[cls_q]) begin
			path_c = PATH_BUMP;
		end else if (BLK_W'(chunks_taken_q) >= BLK_W'(NUM_CHUNKS)) begin
			path_c = PATH_NO_CHUNK;
		end else begin
			path_c = PATH_CLAIM;
		end

		grant_c     = '0;
		chunk_sel_c = chunks_taken_q[CIW-1:0];
		chunk_ok_c  = 1'b1;
		case (path_c)
			PATH_POP: begin
				grant_c     = head_c;
				chunk_sel_c = head_chunk_c[CIW-1:0];
				chunk_ok_c  = head_ok_c;
			end
			PATH_BUMP: begin
				grant_c     = bump_addr_c[ADDR_W-1:0];
				chunk_sel_c = bump_chunk_q[cls_q];
			end
			PATH_CLAIM: begin
				grant_c = claim_base_c[ADDR_W-1:0] + blk_q[ADDR_W-1:0];
			end
			default: grant_c = '0;
		endcase
	end

	// ---------------------------------------------------------------- allocate commit
	logic [AW-1:0] bump_sum_c;
	logic [AW-1:0] new_off_c;
	logic          off_wrap_c;
	logic          alloc_ok_c;

	always_comb begin
		bump_sum_c = AW'(bump_offset_q[cls_q]) + AW'(blk_q);
		new_off_c  = (path_q == PATH_CLAIM) ? (AW'(blk_q) << 1) : bump_sum_c;
		off_wrap_c = new_off_c >= CHUNK_BYTES;
		alloc_ok_c = (path_q == PATH_POP) || (path_q == PATH_BUMP) || (path_q == PATH_CLAIM);
	end

	// ---------------------------------------------------------------- free check
	logic [BLK_W-1:0]  fblk_c;
	logic [ADDR_W-1:0] fmask_c;
	logic [ADDR_W-1:0] faddr_c;
	logic [AW-1:0]     fbase_c;
	logic [AW-1:0]     fdiff_c;
	logic              fcls_ok_c;
	logic              free_ok_c;

	always_comb begin
		fcls_ok_c = {1'b0, tbl_cls_rd} < (CLW + 1)'(NUM_CLASSES);
		fblk_c    = BLK_W'(1) << (5'(tbl_cls_rd) + 5'(MIN_BLOCK_BITS));
		fmask_c   = ~(fblk_c[ADDR_W-1:0] - ADDR_W'(1));
		// A class of 64 KiB blocks has a zero low part: its mask keeps nothing.
		if (fblk_c[ADDR_W]) fmask_c = '0;
		faddr_c   = addr_q & fmask_c;
		fbase_c   = AW'(addr_chunk_c) << CHUNK_BITS;
		fdiff_c   = (AW'(faddr_c) - fbase_c) & (CHUNK_BYTES - AW'(1));
		free_ok_c = range_ok_q && (tbl_live_rd != '0) && fcls_ok_c
		         && !(fdiff_c < AW'(fblk_c)) && (faddr_c != '0);
	end

	// ---------------------------------------------------------------- counters
	logic [COUNT_W-1:0] live_next_c;
	logic [BYTES_W-1:0] bytes_next_c;

	always_comb begin
		live_next_c  = live_count_q;
		bytes_next_c = byte_count_q;
		if (state_q == ST_ALLOC_DONE && alloc_ok_c) begin
			live_next_c  = live_count_q + COUNT_W'(1);
			bytes_next_c = byte_count_q + blk_q[BYTES_W-1:0];
		end else if (state_q == ST_FREE_DONE && free_ok_c) begin
			live_next_c  = live_count_q - COUNT_W'(1);
			bytes_next_c = byte_count_q - fblk_c[BYTES_W-1:0];
		end
	end

	// ---------------------------------------------------------------- chunk table
	always_comb begin
		tbl_req.rd_en       = tbl_rd_en;
		tbl_req.rd_idx      = (state_q == ST_ALLOC_SEL) ? CHUNK_IDX_W'(chunk_sel_c)
		                                                : CHUNK_IDX_W'(addr_chunk_c[CIW-1:0]);
		tbl_req.wr_class_en = alloc_commit && (path_q == PATH_CLAIM);
		tbl_req.wr_class    = CLASS_W'(cls_q);
		tbl_req.wr_live_en  = 1'b0;
		tbl_req.wr_idx      = CHUNK_IDX_W'(chunk_q);
		tbl_req.wr_live     = tbl_live_rd + LIVE_W'(1);
		if (state_q == ST_FREE_DONE) begin
			tbl_req.wr_live_en = free_commit && free_ok_c;
			tbl_req.wr_idx     = CHUNK_IDX_W'(addr_chunk_c[CIW-1:0]);
			tbl_req.wr_live    = tbl_live_rd - LIVE_W'(1);
		end else begin
			tbl_req.wr_live_en = alloc_commit && alloc_ok_c
			                  && ((path_q != PATH_POP) || chunk_ok_q);
			// A freshly claimed chunk starts with one live block, the one just granted.
			if (path_q == PATH_CLAIM) tbl_req.wr_live = LIVE_W'(1);
		end
	end

	scba_chunk_tbl #(
		.NUM_CHUNKS (NUM_CHUNKS),
		.CLASS_BITS (CLW)
	) u_chunk_tbl (
		.clk     (clk),
		.req     (tbl_req),
		.cls_rd  (tbl_cls_rd),
		.live_rd (tbl_live_rd)
	);

	// ---------------------------------------------------------------- link memory
	always_ff @(posedge clk) begin
		if (free_commit && free_ok_c) begin
			link_mem[faddr_c[ADDR_W-1:MIN_BLOCK_BITS]] <= free_head_q[tbl_cls_rd];
		end
	end

	always_ff @(posedge clk) begin
		if (link_rd_en) begin
			link_rd_q <= link_mem[head_c[ADDR_W-1:MIN_BLOCK_BITS]];
		end
	end

	// ---------------------------------------------------------------- item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.data.op;
			size_q <= req.data.size;
			addr_q <= req.data.address;
		end
		if (state_q == ST_DECODE) begin
			cls_q      <= CLW'(cls5_c);
			blk_q      <= BLK_W'(1) << (cls5_c + 5'(MIN_BLOCK_BITS));
			too_big_q  <= too_big_c;
			range_ok_q <= range_ok_c;
		end
		if (state_q == ST_ALLOC_SEL) begin
			path_q     <= path_c;
			grant_q    <= grant_c;
			chunk_q    <= chunk_sel_c;
			chunk_ok_q <= chunk_ok_c;
		end
	end

	// ---------------------------------------------------------------- allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				free_head_q[c]   <= '0;
				bump_chunk_q[c]  <= '0;
				bump_valid_q[c]  <= 1'b0;
				bump_offset_q[c] <= '0;
			end
			chunks_taken_q <= '0;
			live_count_q   <= '0;
			byte_count_q   <= '0;
		end else begin
			if (alloc_commit) begin
				case (path_q)
					PATH_POP: free_head_q[cls_q] <= link_rd_q;
					PATH_BUMP, PATH_CLAIM: begin
						// Advance the bump pointer; drop the chunk once it is used up.
						bump_offset_q[cls_q] <= off_wrap_c ? '0 : new_off_c[CHUNK_BITS-1:0];
						bump_valid_q[cls_q]  <= !off_wrap_c;
						if (path_q == PATH_CLAIM) begin
							bump_chunk_q[cls_q] <= chunks_taken_q[CIW-1:0];
							chunks_taken_q      <= chunks_taken_q + CTW'(1);
						end
					end
					default: chunks_taken_q <= chunks_taken_q;
				endcase
			end
			if (free_commit && free_ok_c) begin
				free_head_q[tbl_cls_rd] <= faddr_c;
			end
			if (alloc_commit || free_commit) begin
				live_count_q <= live_next_c;
				byte_count_q <= bytes_next_c;
			end
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (alloc_commit || free_commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_commit) begin
			rsp_q.block_address <= grant_q;
			rsp_q.size_class    <= (path_q == PATH_TOO_BIG) ? '0 : OUT_CLASS_W'(cls_q);
			rsp_q.live_blocks   <= live_next_c;
			rsp_q.live_bytes    <= bytes_next_c;
			case (path_q)
				PATH_TOO_BIG:  rsp_q.status <= STATUS_TOO_BIG;
				PATH_NO_CHUNK: rsp_q.status <= STATUS_NO_CHUNK;
				default:       rsp_q.status <= STATUS_OK;
			endcase
		end else if (free_commit) begin
			rsp_q.block_address <= '0;
			rsp_q.status        <= STATUS_OK;
			rsp_q.size_class    <= free_ok_c ? OUT_CLASS_W'(tbl_cls_rd) : '0;
			rsp_q.live_blocks   <= live_next_c;
			rsp_q.live_bytes    <= bytes_next_c;
		end
	end

endmodule

// ===== rtl/core/scba_chunk_tbl.sv =====
// Per-chunk class and live-count memories with registered read.
module scba_chunk_tbl #(
	parameter int NUM_CHUNKS = 16,
	parameter int CLASS_BITS = 3
) (
	input  logic                          clk,
	input  scba_pkg::scba_tbl_req_t       req,
	output logic [CLASS_BITS-1:0]         cls_rd,
	output logic [scba_pkg::LIVE_W-1:0]   live_rd
);
	import scba_pkg::*;

	localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

	logic [CLASS_BITS-1:0] class_mem [NUM_CHUNKS];
	logic [LIVE_W-1:0]     live_mem  [NUM_CHUNKS];

	always_ff @(posedge clk) begin
		if (req.wr_class_en) begin
			class_mem[req.wr_idx[IW-1:0]] <= req.wr_class[CLASS_BITS-1:0];
		end
		if (req.wr_live_en) begin
			live_mem[req.wr_idx[IW-1:0]] <= req.wr_live;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			cls_rd  <= class_mem[req.rd_idx[IW-1:0]];
			live_rd <= live_mem[req.rd_idx[IW-1:0]];
		end
	end

endmodule
